>>> rtl/fpa_pkg.sv
// Shared types and opcode codes for the fixed-point ALU.
`default_nettype none

package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_LT      = 4'd4,
    OP_GT      = 4'd5,
    OP_LE      = 4'd6,
    OP_GE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } op_e;

  localparam int unsigned WordW = 32;

  typedef struct packed {
    logic [3:0]              opcode;
    logic signed [WordW-1:0] operand_a;
    logic signed [WordW-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] result_value;
    logic                    compare_true;
    logic                    divide_by_zero;
  } out_t;

  // Control and side data that travel along the divider stages.
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] res;
    logic             cmp;
    logic             dz;
    logic             is_div;
    logic             neg;
    logic [WordW-1:0] dvsr;
  } side_t;

endpackage

`default_nettype wire

>>> rtl/fpa_prep.sv
// First stage: simple ops, multiply and divider operand setup.
`default_nettype none

module fpa_prep import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned DW        = WordW + FRAC_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          ce_i,
  input  wire logic          valid_i,
  input  wire in_t           item_i,
  output      side_t         side_o,
  output      logic [DW-1:0] dvnd_o
);

  side_t                     side_d, side_q;
  logic [DW-1:0]             dvnd_d, dvnd_q;
  logic signed [WordW-1:0]   a, b;
  logic signed [2*WordW-1:0] prod;
  logic [WordW-1:0]          mul_res, abs_a, abs_b, toint_res;

  always_comb begin
    a       = item_i.operand_a;
    b       = item_i.operand_b;
    prod    = a * b;
    mul_res = WordW'(prod >>> FRAC_BITS);
    abs_a   = a[WordW-1] ? WordW'(-a) : WordW'(a);
    abs_b   = b[WordW-1] ? WordW'(-b) : WordW'(b);
    // toint truncates toward zero; magnitude of the most negative word is 2^31
    toint_res = a[WordW-1] ? WordW'(-(abs_a >> FRAC_BITS)) : WordW'(abs_a >> FRAC_BITS);

    side_d        = '0;
    side_d.valid  = valid_i;
    side_d.dvsr   = abs_b;
    side_d.neg    = a[WordW-1] ^ b[WordW-1];
    dvnd_d        = {abs_a, {FRAC_BITS{1'b0}}};

    case (op_e'(item_i.opcode))
      OP_ADD:     side_d.res = WordW'(a + b);
      OP_SUB:     side_d.res = WordW'(a - b);
      OP_MUL:     side_d.res = mul_res;
      OP_DIV: begin
        side_d.is_div = 1'b1;
        side_d.dz     = (b == '0);
        side_d.res    = a;
      end
      OP_LT:      side_d.cmp = (a < b);
      OP_GT:      side_d.cmp = (a > b);
      OP_LE:      side_d.cmp = (a <= b);
      OP_GE:      side_d.cmp = (a >= b);
      OP_EQ:      side_d.cmp = (a == b);
      OP_NE:      side_d.cmp = (a != b);
      OP_MIN:     side_d.res = (a < b) ? a : b;
      OP_MAX:     side_d.res = (a > b) ? a : b;
      OP_INC:     side_d.res = WordW'(a + 32'sd1);
      OP_DEC:     side_d.res = WordW'(a - 32'sd1);
      OP_TOINT:   side_d.res = toint_res;
      OP_FROMINT: side_d.res = WordW'(a <<< FRAC_BITS);
      default:    side_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (ce_i) begin
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      dvnd_q <= dvnd_d;
    end
  end

  assign side_o = side_q;
  assign dvnd_o = dvnd_q;

endmodule

`default_nettype wire

>>> rtl/fpa_div_stage.sv
// One restoring-division stage: produces one quotient bit per item.
`default_nettype none

module fpa_div_stage import fpa_pkg::*; #(
  parameter int unsigned DW = 40
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             ce_i,
  input  wire side_t            side_i,
  input  wire logic [WordW-1:0] rem_i,
  input  wire logic [DW-1:0]    dq_i,
  output      side_t            side_o,
  output      logic [WordW-1:0] rem_o,
  output      logic [DW-1:0]    dq_o
);

  side_t            side_q;
  logic [WordW-1:0] rem_d, rem_q;
  logic [DW-1:0]    dq_d, dq_q;
  logic [WordW:0]   trial, diff;
  logic             take;

  always_comb begin
    trial = {rem_i, dq_i[DW-1]};
    diff  = trial - {1'b0, side_i.dvsr};
    take  = (trial >= {1'b0, side_i.dvsr});
    rem_d = take ? diff[WordW-1:0] : trial[WordW-1:0];
    // shift the next dividend bit out, the quotient bit in
    dq_d  = {dq_i[DW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (ce_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign dq_o   = dq_q;

endmodule

`default_nettype wire

>>> rtl/fixed_point_alu_top.sv
// Top level of the pipelined signed fixed-point ALU.
//
// Usage: present an item (opcode, operand_a, operand_b) on in_i with
// in_valid_i; it is taken on a clock edge where in_ready_o is also high.
// One result item (result_value, compare_true, divide_by_zero) per input
// item leaves on out_o under out_valid_o / out_ready_i, in input order.
// Every opcode takes the same path: one setup/multiply stage, then the divider,
// which resolves one quotient bit per stage over 32 + FRAC_BITS stages,
// then one output register.
// Throughput: one item per cycle while the output is not stalled; all items share one lockstep pipeline.
// Stall: when the output register holds an untaken result, the whole
// pipeline freezes and in_ready_o drops; nothing is lost or repeated.
// An empty output slot lets the pipeline advance, squeezing out bubbles
// at the head.
// Reset: clears all valid bits and side data; the dividend, remainder, quotient and output data are not reset.
`default_nettype none

module fixed_point_alu_top import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output      logic  in_ready_o,
  input  wire in_t   in_i,
  output      logic  out_valid_o,
  input  wire logic  out_ready_i,
  output      out_t  out_o
);

  localparam int unsigned DW = WordW + FRAC_BITS;

  logic             ce;
  side_t            side_w [DW+1];
  logic [WordW-1:0] rem_w  [DW+1];
  logic [DW-1:0]    dq_w   [DW+1];
  logic             out_valid_q;
  out_t             out_d, out_q;
  side_t            last;
  logic [WordW-1:0] quot;

  // Advance everything whenever the output slot is free or being drained.
  assign ce         = !out_valid_q || out_ready_i;
  assign in_ready_o = ce;

  fpa_prep #(
    .FRAC_BITS(FRAC_BITS),
    .DW       (DW)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ce_i   (ce),
    .valid_i(in_valid_i),
    .item_i (in_i),
    .side_o (side_w[0]),
    .dvnd_o (dq_w[0])
  );

  assign rem_w[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_div
    fpa_div_stage #(
      .DW(DW)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ce_i  (ce),
      .side_i(side_w[i]),
      .rem_i (rem_w[i]),
      .dq_i  (dq_w[i]),
      .side_o(side_w[i+1]),
      .rem_o (rem_w[i+1]),
      .dq_o  (dq_w[i+1])
    );
  end

  // Final select: on a nonzero-divisor divide apply the quotient sign, keep the low word; else pass res.
  always_comb begin
    last  = side_w[DW];
    quot  = dq_w[DW][WordW-1:0];
    out_d.compare_true   = last.cmp;
    out_d.divide_by_zero = last.dz;
    if (last.is_div && !last.dz) begin
      out_d.result_value = last.neg ? WordW'(-quot) : quot;
    end else begin
      out_d.result_value = last.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ce) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> sim/fixed_point_alu_checker.sv
// Checker for the fixed-point ALU: predicts each result item and compares it.
`timescale 1ns / 1ps

module fixed_point_alu_checker import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_ready_i,
  input  wire in_t  in_i,
  input  wire logic out_valid_i,
  input  wire logic out_ready_i,
  input  wire out_t out_i,
  output int        fail_count_o,
  output int        pending_o
);

  out_t alu_expected_q[$];

  assign pending_o = alu_expected_q.size();

  function automatic out_t alu_predict(in_t item);
    out_t r;
    logic signed [63:0] a, b, prod, num, quot;
    logic [31:0] mag;
    a = 64'(item.operand_a);
    b = 64'(item.operand_b);
    r = '0;
    case (op_e'(item.opcode))
      OP_ADD: r.result_value = item.operand_a + item.operand_b;
      OP_SUB: r.result_value = item.operand_a - item.operand_b;
      OP_MUL: begin
        prod = a * b;
        r.result_value = 32'(prod >>> FRAC_BITS);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.result_value = item.operand_a;
          r.divide_by_zero = 1'b1;
        end else begin
          num = a <<< FRAC_BITS;
          quot = num / b;
          r.result_value = quot[31:0];
        end
      end
      OP_LT: r.compare_true = a < b;
      OP_GT: r.compare_true = a > b;
      OP_LE: r.compare_true = a <= b;
      OP_GE: r.compare_true = a >= b;
      OP_EQ: r.compare_true = a == b;
      OP_NE: r.compare_true = a != b;
      OP_MIN: r.result_value = (a < b) ? item.operand_a : item.operand_b;
      OP_MAX: r.result_value = (a > b) ? item.operand_a : item.operand_b;
      OP_INC: r.result_value = item.operand_a + 32'sd1;
      OP_DEC: r.result_value = item.operand_a - 32'sd1;
      OP_TOINT: begin
        if (a >= 0) begin
          r.result_value = 32'(item.operand_a) >> FRAC_BITS;
        end else begin
          // negation of the most negative word wraps back to 2^31 unsigned
          mag = -item.operand_a;
          r.result_value = -(mag >> FRAC_BITS);
        end
      end
      default: r.result_value = item.operand_a << FRAC_BITS;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) alu_expected_q.push_back(alu_predict(in_i));
      if (out_valid_i && out_ready_i) begin
        if (alu_expected_q.size() == 0) begin
          report_mismatch("unexpected item", out_i.result_value, 32'h0);
        end else begin
          want = alu_expected_q.pop_front();
          if (out_i.result_value !== want.result_value)
            report_mismatch("result_value", out_i.result_value, want.result_value);
          if (out_i.compare_true !== want.compare_true)
            report_mismatch("compare_true", 32'(out_i.compare_true),
                            32'(want.compare_true));
          if (out_i.divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", 32'(out_i.divide_by_zero),
                            32'(want.divide_by_zero));
        end
      end
    end
  end

endmodule

>>> sim/fixed_point_alu_top_test.sv
// Testbench top for the fixed-point ALU: drives stimulus and gives the verdict.
`timescale 1ns / 1ps

module fixed_point_alu_top_test;
  import fpa_pkg::*;

  localparam int unsigned FracBits = 8;
  localparam int unsigned Latency = FracBits + 34;
  localparam int RandomItems = 1900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  in_t  in_i = '0;
  logic in_ready_o, out_valid_o;
  out_t out_o;
  int   fail_count, pending;
  bit   feed_done = 1'b0;

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  fixed_point_alu_top #(.FRAC_BITS(FracBits)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o
  );

  fixed_point_alu_checker #(.FRAC_BITS(FracBits)) checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_i(out_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Draw an operand that favors the edges of the word and small values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'(int'($urandom_range(0, 1024)) - 512);
      4: return 32'($urandom_range(0, 255)) << FracBits;
      default: return $urandom;
    endcase
  endfunction

  // Send one item: optional idle gap first, then hold valid until taken.
  // Ready is sampled at the edge itself, before the design updates.
  task automatic send_item(op_e op, logic [31:0] a, logic [31:0] b, bit gaps);
    int unsigned wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 11) : 0;
    if (wait_cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (wait_cycles) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= '{opcode: op, operand_a: a, operand_b: b};
    @(posedge clk_i iff in_ready_o);
  endtask

  // Receiver: stall a random count per item, with stretches of full speed.
  initial begin
    int unsigned stall;
    bit eager;
    @(posedge rst_ni);
    forever begin
      eager = ($urandom_range(0, 3) == 0);
      repeat (40) begin
        stall = eager ? 0 : $urandom_range(0, 11);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        @(posedge clk_i iff out_valid_o);
      end
    end
  end

  initial begin
    bit gaps;
    op_e op;
    logic [31:0] edge_words[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0,
                                   32'hffff_ffff, 32'h0000_0100, 32'hffff_ff00};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every opcode on the extreme words, zero divisor, toint of
    // the most negative word, and wrapping add and multiply.
    for (int o = 0; o < 16; o++) begin
      send_item(op_e'(o), edge_words[o % 6], edge_words[(o + 2) % 6], 1'b0);
    end
    send_item(OP_DIV, 32'h1234_5678, 32'h0, 1'b0);
    send_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b0);
    send_item(OP_TOINT, 32'h8000_0000, 32'h0, 1'b0);
    send_item(OP_TOINT, 32'hffff_ff01, 32'h0, 1'b0);
    send_item(OP_ADD, 32'h7fff_ffff, 32'h1, 1'b0);
    send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(OP_EQ, 32'h5555_aaaa, 32'h5555_aaaa, 1'b0);
    send_item(OP_FROMINT, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    in_valid_i <= 1'b0;

    // Hold off until the pipeline has drained completely.
    while (pending != 0) @(posedge clk_i);

    // Random part: bursts of 64 items, each burst randomly with or without idle gaps.
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 64 == 0) gaps = ($urandom_range(0, 3) != 0);
      op = op_e'($urandom_range(0, 15));
      send_item(op, pick_operand(), pick_operand(), gaps);
    end
    in_valid_i <= 1'b0;
    feed_done = 1'b1;

    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Bound the run well above the slowest correct one.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
